// ----- rtl/jsds_pkg.sv -----
package jsds_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_FOUND      = 3'd0,
        ST_NO_SOI     = 3'd1,
        ST_BAD_LEN    = 3'd2,
        ST_SOF_SHORT  = 3'd3,
        ST_ZERO_SIZE  = 3'd4,
        ST_NO_FRAME   = 3'd5
    } t_status;

    // Marker bytes
    localparam logic [7:0] MK_PREFIX  = 8'hFF;
    localparam logic [7:0] MK_SOI     = 8'hD8;
    localparam logic [7:0] MK_EOI     = 8'hD9;
    localparam logic [7:0] MK_SOS     = 8'hDA;
    localparam logic [7:0] MK_RST_LO  = 8'hD0;
    localparam logic [7:0] MK_RST_HI  = 8'hD7;
    localparam logic [7:0] MK_SOF_GRP = 8'hC0;
    localparam logic [7:0] MK_DHT     = 8'hC4;
    localparam logic [7:0] MK_JPG     = 8'hC8;
    localparam logic [7:0] MK_DAC     = 8'hCC;

    // Shortest frame header that still carries height and width
    localparam logic [15:0] SOF_MIN_LEN = 16'd7;

    typedef struct packed {
        t_status     status;
        logic [15:0] width;
        logic [15:0] height;
    } t_result;

    typedef struct packed {
        logic    push;   // a result leaves the parser this cycle
        t_result res;
    } t_res_ctl;

    typedef struct packed {
        logic sent;      // result given, waiting for the last byte
        logic at_start;  // parser sits at its reset point
    } t_scan_stat;

endpackage

// ----- rtl/jsds_in_if.sv -----
interface jsds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/jsds_out_if.sv -----
interface jsds_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;

    modport source (output valid, output status, output width, output height, input ready);
    modport sink   (input valid, input status, input width, input height, output ready);
endinterface

// ----- rtl/jsds_parser.sv -----
module jsds_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output jsds_pkg::t_res_ctl    o_ctl,
    output jsds_pkg::t_scan_stat  o_stat
);
    import jsds_pkg::*;

    typedef enum logic [3:0] {
        PH_SOI0  = 4'd0,
        PH_SOI1  = 4'd1,
        PH_SEEK  = 4'd2,
        PH_FILL  = 4'd3,
        PH_LENHI = 4'd4,
        PH_LENLO = 4'd5,
        PH_BODY  = 4'd6
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_head, n_head;
    logic [7:0]  r_marker, n_marker;
    logic [15:0] r_len, n_len;
    logic [15:0] r_off, n_off;
    logic [15:0] r_h, n_h;
    logic [15:0] r_w, n_w;
    logic        r_sent, n_sent;

    logic        push;
    t_status     st;
    logic        is_frame;

    assign is_frame = ((r_marker & 8'hF0) == MK_SOF_GRP) && (r_marker != MK_DHT)
                      && (r_marker != MK_JPG) && (r_marker != MK_DAC);

    always_comb begin
        n_phase  = r_phase;
        n_head   = r_head;
        n_marker = r_marker;
        n_len    = r_len;
        n_off    = r_off;
        n_h      = r_h;
        n_w      = r_w;
        n_sent   = r_sent;
        push     = 1'b0;
        st       = ST_FOUND;

        if (i_acc && !r_sent) begin
            if (r_head < 3'd4) begin
                n_head = r_head + 3'd1;
            end
            unique case (r_phase)
                PH_SOI0: begin
                    if (i_byte != MK_PREFIX) begin
                        push = 1'b1;
                        st   = ST_NO_SOI;
                    end else begin
                        n_phase = PH_SOI1;
                    end
                end
                PH_SOI1: begin
                    if (i_byte != MK_SOI) begin
                        push = 1'b1;
                        st   = ST_NO_SOI;
                    end else begin
                        n_phase = PH_SEEK;
                    end
                end
                PH_SEEK: begin
                    if (i_byte == MK_PREFIX) begin
                        n_phase = PH_FILL;
                    end
                end
                PH_FILL: begin
                    if (i_byte == MK_PREFIX) begin
                        n_phase = PH_FILL;
                    end else if (i_byte == MK_EOI || i_byte == MK_SOS) begin
                        push = 1'b1;
                        st   = ST_NO_FRAME;
                    end else if (i_byte >= MK_RST_LO && i_byte <= MK_RST_HI) begin
                        n_phase = PH_SEEK;
                    end else begin
                        n_marker = i_byte;
                        n_phase  = PH_LENHI;
                    end
                end
                PH_LENHI: begin
                    n_len   = {8'd0, i_byte};
                    n_off   = 16'd0;
                    n_h     = 16'd0;
                    n_w     = 16'd0;
                    n_phase = PH_LENLO;
                end
                PH_LENLO: begin
                    n_len = {r_len[7:0], i_byte};
                    n_off = 16'd1;
                    if (n_len < 16'd2) begin
                        push = 1'b1;
                        st   = ST_BAD_LEN;
                    end else if (n_len == 16'd2) begin
                        // empty body: segment ends here
                        if (is_frame) begin
                            push = 1'b1;
                            st   = ST_SOF_SHORT;
                        end else begin
                            n_phase = PH_SEEK;
                        end
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_off = r_off + 16'd1;
                    if (n_off == 16'd3 || n_off == 16'd4) begin
                        n_h = {r_h[7:0], i_byte};
                    end else if (n_off == 16'd5 || n_off == 16'd6) begin
                        n_w = {r_w[7:0], i_byte};
                    end
                    if ({1'b0, n_off} + 17'd1 == {1'b0, r_len}) begin
                        if (is_frame) begin
                            push = 1'b1;
                            if (r_len < SOF_MIN_LEN) begin
                                st = ST_SOF_SHORT;
                            end else if (n_h == 16'd0 || n_w == 16'd0) begin
                                st = ST_ZERO_SIZE;
                            end else begin
                                st = ST_FOUND;
                            end
                        end else begin
                            n_phase = PH_SEEK;
                        end
                    end
                end
                default: begin
                    n_phase = PH_SEEK;
                end
            endcase

            // file ends with nothing settled
            if (!push && i_last) begin
                push = 1'b1;
                if (r_head < 3'd3) begin
                    st = ST_NO_SOI;
                end else if (n_phase == PH_BODY) begin
                    st = ST_BAD_LEN;
                end else begin
                    st = ST_NO_FRAME;
                end
            end
            if (push) begin
                n_sent = 1'b1;
            end
        end

        // last byte rearms for the next file
        if (i_acc && i_last) begin
            n_phase  = PH_SOI0;
            n_head   = 3'd0;
            n_marker = 8'd0;
            n_len    = 16'd0;
            n_off    = 16'd0;
            n_h      = 16'd0;
            n_w      = 16'd0;
            n_sent   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SOI0;
            r_head   <= 3'd0;
            r_marker <= 8'd0;
            r_len    <= 16'd0;
            r_off    <= 16'd0;
            r_h      <= 16'd0;
            r_w      <= 16'd0;
            r_sent   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_head   <= n_head;
            r_marker <= n_marker;
            r_len    <= n_len;
            r_off    <= n_off;
            r_h      <= n_h;
            r_w      <= n_w;
            r_sent   <= n_sent;
        end
    end

    // sizes are reported only with a found status; taken before the rearm
    always_comb begin
        o_ctl.push       = push;
        o_ctl.res.status = st;
        o_ctl.res.width  = (st == ST_FOUND) ? ((r_phase == PH_BODY && r_off + 16'd1 == 16'd5)
                           || (r_phase == PH_BODY && r_off + 16'd1 == 16'd6)
                           ? {r_w[7:0], i_byte} : r_w) : 16'd0;
        o_ctl.res.height = (st == ST_FOUND) ? r_h : 16'd0;
    end

    assign o_stat.sent     = r_sent;
    assign o_stat.at_start = (r_phase == PH_SOI0) && (r_head == 3'd0);

endmodule

// ----- rtl/jsds_out_reg.sv -----
module jsds_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jsds_pkg::t_res_ctl  i_ctl,
    output logic                o_space,
    jsds_out_if.source          o_res
);
    import jsds_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_ctl.push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_ctl.push) begin
            r_res <= i_ctl.res;
        end
    end

    assign o_res.valid  = r_valid;
    assign o_res.status = r_res.status;
    assign o_res.width  = r_res.width;
    assign o_res.height = r_res.height;

endmodule

// ----- rtl/jpeg_sof_dimension_scanner_top.sv -----
// Channel   Dir  Payload                          Request
// i_in      in   data_byte[7:0], last_byte        one file byte
// o_res     out  status[2:0], width, height       one result per file
//
// One byte is taken every cycle while the result register is empty or
// being drained; the parser state advances on that edge.
// A result shows on o_res in the cycle after the byte that settles it.
// A stalled result holds i_in.ready low; nothing else throttles input.
// Synchronous active-low reset puts the parser at the start of a file.
module jpeg_sof_dimension_scanner_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsds_in_if.sink    i_in,
    jsds_out_if.source o_res
);
    import jsds_pkg::*;

    logic       acc;
    logic       space;
    t_res_ctl   ctl;
    t_scan_stat stat;

    assign i_in.ready = space;
    assign acc        = i_in.valid && space;

    // marker hunt, length tracking and frame size capture
    jsds_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_byte  (i_in.data_byte),
        .i_last  (i_in.last_byte),
        .o_ctl   (ctl),
        .o_stat  (stat)
    );

    // result register toward the sink
    jsds_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_space (space),
        .o_res   (o_res)
    );

    // results come only from accepted bytes
    a_push_on_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push |-> acc)
        else $error("result without an accepted byte");

    // one result per file: none follows until the last byte rearms
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push && !i_in.last_byte |=> !ctl.push)
        else $error("second result in one file");

    // last byte rearms the parser
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in.last_byte |=> !stat.sent && stat.at_start)
        else $error("parser not rearmed after last byte");

endmodule

// ----- bench/jpeg_sof_dimension_scanner_top_tb.sv -----
module jpeg_sof_dimension_scanner_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsds_pkg::*;

    // Cycles with no request taken on either side before the run is declared hung.
    // The longest deliberate hold-off is HOLD_CYCLES, well inside this.
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    // Result shows in the cycle after the byte that settles it; the rest is spare.
    localparam int DRAIN_CYCLES = 8;

    typedef logic [7:0] t_byte_seq[$];

    // Local copy of the parser position within a file
    typedef enum logic [2:0] {
        SCAN_SOI_FF,
        SCAN_SOI_D8,
        SCAN_HUNT,
        SCAN_FILL,
        SCAN_LEN_HI,
        SCAN_LEN_LO,
        SCAN_BODY
    } t_scan_phase;

    logic i_clk;
    logic i_rst_n;

    jsds_in_if  in_ch ();
    jsds_out_if res_ch ();

    jpeg_sof_dimension_scanner_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    // ------------------------------------------------------------------
    // Predicted parser state
    // ------------------------------------------------------------------
    t_scan_phase scan_phase;
    logic [2:0]  hdr_cnt;       // saturates at 4; first bytes of the file
    logic [7:0]  seg_marker;
    logic [15:0] seg_len;
    logic [15:0] seg_pos;
    logic [15:0] frm_height;
    logic [15:0] frm_width;
    logic        res_given;     // result out, now waiting for the last byte

    t_result pending_results[$];

    // Bench bookkeeping
    int mismatches;
    int files_sent;
    int bytes_taken;
    int results_seen;
    int status_seen[6];
    int quiet_cycles;

    // Flow control knobs, percent of cycles
    int sender_idle_pct;
    int recv_stall_pct;
    logic hold_req;
    int   hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_scan();
        scan_phase = SCAN_SOI_FF;
        hdr_cnt    = '0;
        seg_marker = '0;
        seg_len    = '0;
        seg_pos    = '0;
        frm_height = '0;
        frm_width  = '0;
        res_given  = 1'b0;
    endfunction

    // C0..CF except DHT, JPG and DAC carry a frame header
    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m[7:4] == MK_SOF_GRP[7:4]) && (m != MK_DHT) && (m != MK_JPG)
               && (m != MK_DAC);
    endfunction

    // Final byte of a segment: a frame header settles the file, anything else
    // sends the parser back to hunting.
    function automatic void close_segment(output logic got, output t_status st);
        got = 1'b0;
        st  = ST_FOUND;
        if (is_frame_marker(seg_marker)) begin
            got = 1'b1;
            if (seg_len < SOF_MIN_LEN)
                st = ST_SOF_SHORT;
            else if (frm_height == '0 || frm_width == '0)
                st = ST_ZERO_SIZE;
        end else begin
            scan_phase = SCAN_HUNT;
        end
    endfunction

    // Advances the predicted parser by one accepted byte and queues the
    // result it settles, if any.
    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic [2:0] hdr_before;
        logic       got;
        t_status    st;
        t_result    r;

        hdr_before = hdr_cnt;
        got = 1'b0;
        st  = ST_FOUND;

        // Outcome already given: swallow bytes until the end of the file
        if (res_given) begin
            if (last)
                clear_scan();
            return;
        end
        if (hdr_cnt < 3'd4)
            hdr_cnt++;

        case (scan_phase)
            SCAN_SOI_FF: begin
                if (b != MK_PREFIX) begin
                    got = 1'b1;
                    st  = ST_NO_SOI;
                end else
                    scan_phase = SCAN_SOI_D8;
            end
            SCAN_SOI_D8: begin
                if (b != MK_SOI) begin
                    got = 1'b1;
                    st  = ST_NO_SOI;
                end else
                    scan_phase = SCAN_HUNT;
            end
            SCAN_HUNT: begin
                if (b == MK_PREFIX)
                    scan_phase = SCAN_FILL;
            end
            SCAN_FILL: begin
                // runs of FF are fill; restart markers carry no length
                if (b == MK_EOI || b == MK_SOS) begin
                    got = 1'b1;
                    st  = ST_NO_FRAME;
                end else if (b >= MK_RST_LO && b <= MK_RST_HI)
                    scan_phase = SCAN_HUNT;
                else if (b != MK_PREFIX) begin
                    seg_marker = b;
                    scan_phase = SCAN_LEN_HI;
                end
            end
            SCAN_LEN_HI: begin
                seg_len    = {8'h00, b};
                seg_pos    = '0;
                frm_height = '0;
                frm_width  = '0;
                scan_phase = SCAN_LEN_LO;
            end
            SCAN_LEN_LO: begin
                seg_len = {seg_len[7:0], b};
                seg_pos = 16'd1;
                if (seg_len < 16'd2) begin
                    got = 1'b1;
                    st  = ST_BAD_LEN;
                end else if (seg_len == 16'd2)
                    close_segment(got, st);
                else
                    scan_phase = SCAN_BODY;
            end
            default: begin
                // body: offsets 3,4 height and 5,6 width, big-endian
                seg_pos++;
                if (seg_pos == 16'd3 || seg_pos == 16'd4)
                    frm_height = {frm_height[7:0], b};
                else if (seg_pos == 16'd5 || seg_pos == 16'd6)
                    frm_width = {frm_width[7:0], b};
                if ({1'b0, seg_pos} + 17'd1 == {1'b0, seg_len})
                    close_segment(got, st);
            end
        endcase

        // End of file with nothing settled yet
        if (!got && last) begin
            got = 1'b1;
            if (hdr_before < 3'd3)
                st = ST_NO_SOI;
            else if (scan_phase == SCAN_BODY)
                st = ST_BAD_LEN;
            else
                st = ST_NO_FRAME;
        end

        if (got) begin
            r.status = st;
            r.width  = (st == ST_FOUND) ? frm_width : 16'd0;
            r.height = (st == ST_FOUND) ? frm_height : 16'd0;
            pending_results.insert(pending_results.size(), r);
            res_given = 1'b1;
            if (last)
                clear_scan();
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: takes both channels at the rising edge, predicts on each
    // accepted byte, checks each accepted result, and watches for a hang.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        logic    took_in;
        logic    took_out;

        took_in  = in_ch.valid && in_ch.ready;
        took_out = res_ch.valid && res_ch.ready;

        if (!i_rst_n) begin
            clear_scan();
        end else begin
            if (took_in) begin
                bytes_taken++;
                scan_byte(in_ch.data_byte, in_ch.last_byte);
            end
            if (took_out) begin
                results_seen++;
                if (res_ch.status < 3'd6)
                    status_seen[res_ch.status]++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: status %0d width %0d height %0d",
                           res_ch.status, res_ch.width, res_ch.height);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_ch.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, res_ch.status);
                        mismatches++;
                    end
                    if (res_ch.width !== want.width) begin
                        $error("width mismatch: expected %0d, got %0d",
                               want.width, res_ch.width);
                        mismatches++;
                    end
                    if (res_ch.height !== want.height) begin
                        $error("height mismatch: expected %0d, got %0d",
                               want.height, res_ch.height);
                        mismatches++;
                    end
                end
            end

            if (took_in || took_out)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request so that
    // the result register fills and the byte input backs up.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after the byte
    // was taken. Valid stays up between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_file(input t_byte_seq f);
        foreach (f[i])
            send_byte(f[i], i == f.size() - 1);
        files_sent++;
    endtask

    // Appends one byte to the end of a file
    function automatic void add_byte(ref t_byte_seq f, input logic [7:0] b);
        f.insert(f.size(), b);
    endfunction

    // Height/width with extra weight on the corners
    function automatic logic [15:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'h0000;
        if (r < 20)
            return 16'hFFFF;
        if (r < 25)
            return 16'h0001;
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // Marker, length and body; the body is capped so long lengths run off
    // the end of the file.
    function automatic void add_segment(ref t_byte_seq f, input logic [7:0] mk,
                                        input logic [15:0] len,
                                        input logic [15:0] h, input logic [15:0] w);
        add_byte(f, MK_PREFIX);
        add_byte(f, mk);
        add_byte(f, len[15:8]);
        add_byte(f, len[7:0]);
        for (int k = 2; k < len && k < 14; k++) begin
            case (k)
                3:       add_byte(f, h[15:8]);
                4:       add_byte(f, h[7:0]);
                5:       add_byte(f, w[15:8]);
                6:       add_byte(f, w[7:0]);
                default: add_byte(f, 8'($urandom_range(255)));
            endcase
        end
    endfunction

    // Mostly well-formed files with random content; some noise, corrupt
    // start markers and truncated files.
    function automatic t_byte_seq make_file();
        t_byte_seq   f;
        int          r;
        int          n;
        logic [7:0]  m;
        logic [15:0] len;

        if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(1, 6))
                add_byte(f, 8'($urandom_range(255)));
            return f;
        end

        add_byte(f, ($urandom_range(99) < 4) ? 8'($urandom_range(255)) : MK_PREFIX);
        add_byte(f, ($urandom_range(99) < 4) ? 8'($urandom_range(255)) : MK_SOI);

        // Stuff ahead of the frame header
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(3))
                0: repeat ($urandom_range(1, 3))
                       add_byte(f, 8'($urandom_range(255)));
                1: begin
                    repeat ($urandom_range(1, 3))
                        add_byte(f, MK_PREFIX);
                    add_byte(f, 8'(MK_RST_LO + $urandom_range(7)));
                end
                default: begin
                    case ($urandom_range(5))
                        0:       m = MK_DHT;
                        1:       m = MK_JPG;
                        2:       m = MK_DAC;
                        3:       m = 8'(8'hE0 + $urandom_range(15));
                        4:       m = 8'hDB;
                        default: m = 8'($urandom_range(255));
                    endcase
                    add_segment(f, m, 16'($urandom_range(2, 10)), pick_dim(), pick_dim());
                end
            endcase
        end

        // How the file ends: EOI/SOS, nothing, or a frame header
        r = $urandom_range(9);
        if (r == 0) begin
            add_byte(f, MK_PREFIX);
            add_byte(f, ($urandom_range(1) != 0) ? MK_EOI : MK_SOS);
        end else if (r > 1) begin
            do
                m = 8'(MK_SOF_GRP + $urandom_range(15));
            while (!is_frame_marker(m));
            r = $urandom_range(99);
            if (r < 8)
                len = 16'($urandom_range(0, 6));
            else if (r < 12)
                len = 16'(16'h0100 + $urandom_range(16'hFEFF));
            else
                len = 16'($urandom_range(7, 12));
            add_segment(f, m, len, pick_dim(), pick_dim());
        end

        repeat ($urandom_range(0, 2))
            add_byte(f, 8'($urandom_range(255)));

        if ($urandom_range(99) < 10 && f.size() > 1) begin
            n = $urandom_range(1, f.size() - 1);
            while (f.size() > n)
                void'(f.pop_back());
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Wrong start bytes, files too short to hold a start marker, and one ending on EOI
    task automatic test_start_marker();
        send_file('{8'h00});
        send_file('{8'hFF, 8'h00, 8'h12});
        send_file('{8'hFF, 8'hD8});
        send_file('{8'hFF, 8'hD8, 8'hFF});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hD9});
    endtask

    // Stray bytes, fill, restarts, start of scan, and files that end while
    // hunting, on a marker, on a length byte, or right after a segment
    task automatic test_marker_hunt();
        send_file('{8'hFF, 8'hD8, 8'h12, 8'hFF, 8'hFF, 8'hD3, 8'hFF, 8'hDA, 8'h55});
        send_file('{8'hFF, 8'hD8, 8'h00, 8'h00});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hC4});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h04, 8'hAA, 8'hBB});
    endtask

    // Frame headers with the largest and smallest sizes; the second one
    // settles on the last byte of the file
    task automatic test_frame_found();
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h0B, 8'h08, 8'hFF, 8'hFF,
                    8'hFF, 8'hFF, 8'h03, 8'h01, 8'h11, 8'h00, 8'h00});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hCF, 8'h00, 8'h07, 8'h08, 8'h00, 8'h01,
                    8'h00, 8'h01});
    endtask

    // Bad lengths, short and zero-size frame headers, cut-off segments
    task automatic test_segment_errors();
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h00, 8'h77});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hC1, 8'h00, 8'h01});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hC2, 8'h00, 8'h02, 8'hEE});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hC3, 8'h00, 8'h06, 8'h08, 8'h00, 8'h10,
                    8'h00, 8'h00});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hC9, 8'h00, 8'h08, 8'h08, 8'h00, 8'h00,
                    8'h00, 8'h20, 8'h03, 8'h00});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h11, 8'h08, 8'h00, 8'h10});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'h01});
    endtask

    task automatic test_random_files(input int idle_pct, input int stall_pct,
                                     input int byte_budget);
        t_byte_seq f;
        int        sent;

        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        sent = 0;
        while (sent < byte_budget) begin
            f = make_file();
            send_file(f);
            sent += f.size();
        end
    endtask

    // Result side holds off while short files keep coming: the result
    // register fills and the byte input has to stall
    task automatic test_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_req = 1'b1;
        repeat (6)
            send_file('{8'h00});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h07, 8'h08, 8'h12, 8'h34,
                    8'h56, 8'h78});
        send_file('{8'hFF, 8'hD8, 8'hFF, 8'hD9});
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        res_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        hold_req        = 1'b0;
        hold_left       = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        mismatches      = 0;
        files_sent      = 0;
        bytes_taken     = 0;
        results_seen    = 0;
        quiet_cycles    = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_start_marker();
        test_marker_hunt();
        test_frame_found();
        test_segment_errors();

        test_random_files(0, 0, 250);
        test_random_files(53, 0, 250);
        test_random_files(0, 53, 250);
        test_random_files(13, 13, 250);

        test_backpressure();

        in_ch.valid    <= 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d files (%0d bytes accepted), checked %0d results.",
                 files_sent, bytes_taken, results_seen);
        $display("Status mix: found %0d, no-soi %0d, bad-len %0d, short %0d, %s %0d, %s %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 "zero", status_seen[4], "none", status_seen[5]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/jsds_pkg.sv
rtl/jsds_in_if.sv
rtl/jsds_out_if.sv
rtl/jsds_parser.sv
rtl/jsds_out_reg.sv
rtl/jpeg_sof_dimension_scanner_top.sv
bench/jpeg_sof_dimension_scanner_top_tb.sv
